@@ hw/rtl/uer_pkg.sv @@
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

   localparam int PHASE_CNT_BITS = 24;
   localparam int PULSE_BITS     = 24;
   localparam int DIST_BITS      = 16;
   localparam int TRIG_BITS      = 16;
   localparam int SCALE_BITS     = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_TIMEOUT = 2'd1;
   localparam status_type ST_RANGE   = 2'd2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_TRIGGER_TICKS  = 3'd0;
   localparam csr_index_type REG_TIMEOUT_TICKS  = 3'd1;
   localparam csr_index_type REG_DISTANCE_SCALE = 3'd2;
   localparam csr_index_type REG_MIN_DISTANCE   = 3'd3;
   localparam csr_index_type REG_MAX_DISTANCE   = 3'd4;

   // Per-tick flags passed from the sequencer to the result stage.
   typedef struct packed {
      logic trig;
      logic busy;
      logic done;
      logic timeout;
   } seq_info_type;

endpackage

@@ hw/rtl/uer_seq.sv @@
// Measurement sequencer: trigger timing, echo edge tracking, width count.
module uer_seq #(
   parameter int COUNTER_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                start_request,
   input  logic                                echo_level,
   input  logic [uer_pkg::TRIG_BITS-1:0]       trigger_ticks,
   input  logic [uer_pkg::PHASE_CNT_BITS-1:0]  timeout_ticks,
   output uer_pkg::seq_info_type               info,
   output logic [COUNTER_BITS-1:0]             width
);
   import uer_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_TRIG,
      PH_RISE,
      PH_FALL
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [PHASE_CNT_BITS-1:0]  phase_cnt_ff, phase_cnt_in, cnt_inc;
   logic [COUNTER_BITS-1:0]    width_ff, width_in;
   logic                       echo_prev_ff;
   seq_info_type               info_ff, info_in;
   logic [COUNTER_BITS-1:0]    width_out_ff;
   logic                       rise, fall, fall_end;

   assign rise    = echo_level & ~echo_prev_ff;
   assign fall    = ~echo_level & echo_prev_ff;
   assign cnt_inc = phase_cnt_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      phase_cnt_in = phase_cnt_ff;
      width_in     = width_ff;
      info_in      = '0;
      fall_end     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               phase_in     = PH_LEAD;
               phase_cnt_in = '0;
            end
         end
         PH_LEAD, PH_TRIG: begin
            info_in.trig = (phase_ff == PH_TRIG);
            phase_cnt_in = cnt_inc;
            if (cnt_inc >= PHASE_CNT_BITS'(trigger_ticks)) begin
               phase_in     = (phase_ff == PH_LEAD) ? PH_TRIG : PH_RISE;
               phase_cnt_in = '0;
            end
         end
         PH_RISE, PH_FALL: begin
            phase_cnt_in = cnt_inc;
            if (phase_ff == PH_RISE && rise) begin
               phase_in = PH_FALL;
               width_in = '0;
            end else if (phase_ff == PH_FALL) begin
               width_in = width_ff + 1'b1;
               if (fall) begin
                  fall_end     = 1'b1;
                  info_in.done = 1'b1;
                  phase_in     = PH_IDLE;
                  phase_cnt_in = '0;
               end
            end
            // a closing edge on the timeout tick wins
            if (!fall_end && cnt_inc >= timeout_ticks) begin
               info_in.done    = 1'b1;
               info_in.timeout = 1'b1;
               phase_in        = PH_IDLE;
               phase_cnt_in    = '0;
            end
         end
         default: begin
            phase_in     = PH_IDLE;
            phase_cnt_in = '0;
         end
      endcase
      info_in.busy = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         phase_cnt_ff <= '0;
         width_ff     <= '0;
         echo_prev_ff <= 1'b0;
         info_ff      <= '0;
         width_out_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         phase_cnt_ff <= phase_cnt_in;
         width_ff     <= width_in;
         echo_prev_ff <= echo_level;
         info_ff      <= info_in;
         width_out_ff <= width_in;
      end
   end

   assign info  = info_ff;
   assign width = width_out_ff;

endmodule

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: handshakes, registers, distance stage.
// A request word passes the sequencer register and then the response register.
// Throughput: one request word per cycle unless the response channel stalls;
//   the distance multiply sits in a second stage behind the sequencer state loop.
// Reset (synchronous, active high): sequencer idle, counters and echo history
//   cleared, registers at their defaults, both pipeline stages empty.
module ultrasonic_echo_ranger #(
   parameter int COUNTER_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel: one word per timing tick
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_request,
   input  logic                                req_echo_level,
   // response channel: one word per request word
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_trigger_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output uer_pkg::status_type                 rsp_status,
   output logic [uer_pkg::PULSE_BITS-1:0]      rsp_echo_ticks,
   output logic [uer_pkg::DIST_BITS-1:0]       rsp_distance,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  uer_pkg::csr_index_type              csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import uer_pkg::*;

   localparam int PROD_BITS = COUNTER_BITS + SCALE_BITS;

   // ---------------- registers ----------------
   logic [TRIG_BITS-1:0]      trigger_ticks_ff;
   logic [PHASE_CNT_BITS-1:0] timeout_ticks_ff;
   logic [SCALE_BITS-1:0]     distance_scale_ff;
   logic [DIST_BITS-1:0]      min_distance_ff;
   logic [DIST_BITS-1:0]      max_distance_ff;
   logic                      csr_write;

   // writes always complete; indexes past the list are dropped
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff  <= TRIG_BITS'(80);
         timeout_ticks_ff  <= PHASE_CNT_BITS'(1600000);
         distance_scale_ff <= SCALE_BITS'(112394);
         min_distance_ff   <= DIST_BITS'(200);
         max_distance_ff   <= DIST_BITS'(30000);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TRIGGER_TICKS:  trigger_ticks_ff  <= csr_data[TRIG_BITS-1:0];
            REG_TIMEOUT_TICKS:  timeout_ticks_ff  <= csr_data[PHASE_CNT_BITS-1:0];
            REG_DISTANCE_SCALE: distance_scale_ff <= csr_data[SCALE_BITS-1:0];
            REG_MIN_DISTANCE:   min_distance_ff   <= csr_data[DIST_BITS-1:0];
            REG_MAX_DISTANCE:   max_distance_ff   <= csr_data[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // Stage 1 lives in the sequencer; stage 2 is the response register.
   // A stage moves when the one behind it is empty or draining this cycle.
   logic s1_valid_ff, s1_valid_in;
   logic s1_move, req_accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_move    = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_move;
   assign req_accept = req_valid & req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage 1: sequencer ----------------
   // State advances only on accepted words, so stalls never count as ticks.
   seq_info_type            s1_info;
   logic [COUNTER_BITS-1:0] s1_width;

   uer_seq #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (req_accept),
      .start_request (req_start_request),
      .echo_level    (req_echo_level),
      .trigger_ticks (trigger_ticks_ff),
      .timeout_ticks (timeout_ticks_ff),
      .info          (s1_info),
      .width         (s1_width)
   );

   // ---------------- stage 2: distance and range check ----------------
   // distance = (width * scale) >> 20, checked on the untruncated quotient
   logic [PROD_BITS-1:0]    product;
   logic [COUNTER_BITS-1:0] dist_full;
   logic                    out_of_range;
   status_type              status_in;
   logic [PULSE_BITS-1:0]   pulse_in;
   logic [DIST_BITS-1:0]    dist_in;

   assign product      = PROD_BITS'(s1_width) * PROD_BITS'(distance_scale_ff);
   assign dist_full    = product[PROD_BITS-1:SCALE_BITS];
   assign out_of_range = (dist_full < COUNTER_BITS'(min_distance_ff)) ||
                         (dist_full > COUNTER_BITS'(max_distance_ff));

   always_comb begin
      status_in = ST_OK;
      pulse_in  = '0;
      dist_in   = '0;
      if (s1_info.done) begin
         if (s1_info.timeout) begin
            status_in = ST_TIMEOUT;
         end else begin
            pulse_in = PULSE_BITS'(s1_width);
            if (out_of_range) begin
               status_in = ST_RANGE;
            end else begin
               dist_in = dist_full[DIST_BITS-1:0];
            end
         end
      end
   end

   logic                  rsp_trig_ff, rsp_busy_ff, rsp_done_ff;
   status_type            rsp_status_ff;
   logic [PULSE_BITS-1:0] rsp_pulse_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_trig_ff   <= s1_info.trig;
         rsp_busy_ff   <= s1_info.busy;
         rsp_done_ff   <= s1_info.done;
         rsp_status_ff <= status_in;
         rsp_pulse_ff  <= pulse_in;
         rsp_dist_ff   <= dist_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = rsp_trig_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_echo_ticks    = rsp_pulse_ff;
   assign rsp_distance      = rsp_dist_ff;

   // ---------------- checks ----------------
   // a finished measurement always returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done word reports busy");

   // trigger is only driven during a measurement
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trigger_level) |-> rsp_busy_res)
      else $error("trigger high while idle");

   // timeout carries no width and no distance
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_TIMEOUT) |->
         (rsp_done_res && rsp_echo_ticks == '0 && rsp_distance == '0))
      else $error("timeout word carries data");

   // words without done carry no result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |->
         (rsp_status == ST_OK && rsp_echo_ticks == '0 && rsp_distance == '0))
      else $error("result fields set without done");

endmodule
